// ===== rtl/gli_pkg.sv =====
// ----------------------------------------------------------------------------
// gli_pkg
// Shared types and constants of the piecewise-linear gamma curve block.
// ----------------------------------------------------------------------------
package gli_pkg;

    // Default sizes of the curve store
    localparam int MAX_NODES_DEF      = 256;
    localparam int NODE_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int SAMPLE_W   = 32;  // signed channel sample
    localparam int DEPTH_W    = 16;  // widest input or output channel depth
    localparam int BITS_W     = 5;   // bit-depth register
    localparam int NIDX_W     = 8;   // node index field
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Register reset values
    localparam int IN_BITS_RST    = 12;
    localparam int OUT_BITS_RST   = 8;
    localparam int NODE_COUNT_RST = 33;

    // Item kinds
    localparam logic KIND_NODE  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_BITS  = 2'd0,
        CFG_OUTPUT_BITS = 2'd1,
        CFG_NODE_COUNT  = 2'd2
    } t_cfg_idx;

    // Live depth settings seen by every channel
    typedef struct packed {
        logic [BITS_W-1:0]  ib;       // input bits, 1..16
        logic [BITS_W-1:0]  ob;       // output bits, 1..16
        logic [DEPTH_W-1:0] in_max;   // 2^ib - 1
        logic [DEPTH_W-1:0] out_max;  // 2^ob - 1
    } t_depth_cfg;

endpackage

// ===== rtl/gli_if.sv =====
// ----------------------------------------------------------------------------
// gli_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface gli_in_if
    import gli_pkg::*;
#(
    parameter int NODE_W = NODE_FRAC_BITS_DEF + 1
);
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [NIDX_W-1:0]          node_index;
    logic [NODE_W-1:0]          node_value;
    logic signed [SAMPLE_W-1:0] blue_in;
    logic signed [SAMPLE_W-1:0] green_in;
    logic signed [SAMPLE_W-1:0] red_in;

    modport source (output valid, kind, node_index, node_value, blue_in, green_in, red_in,
                    input ready);
    modport sink   (input valid, kind, node_index, node_value, blue_in, green_in, red_in,
                    output ready);
endinterface

interface gli_out_if
    import gli_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] blue_out;
    logic [DEPTH_W-1:0] green_out;
    logic [DEPTH_W-1:0] red_out;

    modport source (output valid, blue_out, green_out, red_out, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

interface gli_cfg_if
    import gli_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rgb_gamma_lut_interp.sv =====
// ----------------------------------------------------------------------------
// rgb_gamma_lut_interp
// Piecewise-linear gamma curve on the blue, green and red channels of a
// pixel, with curve nodes loaded through the item stream.
//
//   port    dir   carries
//   i_pix   in    node write (kind 0) or pixel (kind 1)
//   o_res   out   corrected pixel, one per pixel item
//   i_cfg   in    depth and node count registers, always ready
//
// One item per cycle while no result waits; a pixel result passes the clamp,
// scale, node read, multiply, sum, scale and output stages in turn.
// Node writes travel the same pipe and reach the store in item order.
// A stalled result freezes the whole pipe; i_pix.ready follows it.
// Synchronous reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module rgb_gamma_lut_interp
    import gli_pkg::*;
#(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int NODE_FRAC_BITS = NODE_FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gli_in_if.sink    i_pix,
    gli_out_if.source o_res,
    gli_cfg_if.sink   i_cfg
);
    localparam int IW      = $clog2(MAX_NODES);
    localparam int W       = NODE_FRAC_BITS + 1;
    localparam int NPIPE   = 6;
    localparam int NM1_RST = ((NODE_COUNT_RST < MAX_NODES) ? NODE_COUNT_RST : MAX_NODES) - 1;

    logic [BITS_W-1:0] r_ib;
    logic [BITS_W-1:0] r_ob;
    logic [IW-1:0]     r_nm1;
    logic [BITS_W-1:0] n_bits;
    logic [IW-1:0]     n_nm1;
    t_depth_cfg        dcfg;

    logic              en;
    logic [NPIPE-1:0]  r_vld;
    logic [NPIPE-1:0]  r_kind;
    logic [NIDX_W-1:0] r_ni [2];
    logic [W-1:0]      r_nv [2];
    logic              we;

    logic                       r_out_valid;
    logic [DEPTH_W-1:0]         r_out [3];
    logic signed [SAMPLE_W-1:0] raw   [3];
    logic [IW-1:0]              idx   [3];
    logic [DEPTH_W-1:0]         frac  [3];
    logic [W-1:0]               c0    [3];
    logic [W-1:0]               c1    [3];
    logic [DEPTH_W-1:0]         res   [3];

    // Saturate configuration data to 1..16 and 2..MAX_NODES
    always_comb begin
        if (i_cfg.data[BITS_W-1:0] == '0) begin
            n_bits = BITS_W'(1);
        end else if (i_cfg.data[BITS_W-1:0] > BITS_W'(DEPTH_W)) begin
            n_bits = BITS_W'(DEPTH_W);
        end else begin
            n_bits = i_cfg.data[BITS_W-1:0];
        end
        if (int'(i_cfg.data) < 2) begin
            n_nm1 = IW'(1);
        end else if (int'(i_cfg.data) > MAX_NODES) begin
            n_nm1 = IW'(MAX_NODES - 1);
        end else begin
            n_nm1 = IW'(int'(i_cfg.data) - 1);
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib  <= BITS_W'(IN_BITS_RST);
            r_ob  <= BITS_W'(OUT_BITS_RST);
            r_nm1 <= IW'(NM1_RST);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_INPUT_BITS:  r_ib  <= n_bits;
                CFG_OUTPUT_BITS: r_ob  <= n_bits;
                CFG_NODE_COUNT:  r_nm1 <= n_nm1;
                default: ;
            endcase
        end
    end

    assign dcfg.ib      = r_ib;
    assign dcfg.ob      = r_ob;
    assign dcfg.in_max  = DEPTH_W'((17'd1 << r_ib) - 17'd1);
    assign dcfg.out_max = DEPTH_W'((17'd1 << r_ob) - 17'd1);

    // Advance the pipe unless a result waits
    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;

    // Item control and node-write fields along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NPIPE-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= {r_kind[NPIPE-2:0], i_pix.kind};
            r_ni[0] <= i_pix.node_index;
            r_nv[0] <= i_pix.node_value;
            r_ni[1] <= r_ni[0];
            r_nv[1] <= r_nv[0];
        end
    end

    // Node write issues at the read stage, in item order with pixel reads
    assign we = r_vld[1] && (r_kind[1] == KIND_NODE) && (int'(r_ni[1]) < MAX_NODES);

    assign raw[0] = i_pix.blue_in;
    assign raw[1] = i_pix.green_in;
    assign raw[2] = i_pix.red_in;

    // One lane per color channel
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        gli_front #(
            .MAX_NODES (MAX_NODES)
        ) u_front (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cfg  (dcfg),
            .i_nm1  (r_nm1),
            .i_raw  (raw[ch]),
            .o_idx  (idx[ch]),
            .o_frac (frac[ch])
        );

        gli_node_mem #(
            .MAX_NODES      (MAX_NODES),
            .NODE_FRAC_BITS (NODE_FRAC_BITS)
        ) u_mem (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (we),
            .i_waddr (IW'(r_ni[1])),
            .i_wdata (r_nv[1]),
            .i_idx   (idx[ch]),
            .o_c0    (c0[ch]),
            .o_c1    (c1[ch])
        );

        gli_back #(
            .NODE_FRAC_BITS (NODE_FRAC_BITS)
        ) u_back (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cfg  (dcfg),
            .i_frac (frac[ch]),
            .i_c0   (c0[ch]),
            .i_c1   (c1[ch]),
            .o_res  (res[ch])
        );
    end

    // Output register: load pixel results, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[NPIPE-1] && (r_kind[NPIPE-1] == KIND_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[NPIPE-1] && (r_kind[NPIPE-1] == KIND_PIXEL)) begin
            r_out[0] <= res[0];
            r_out[1] <= res[1];
            r_out[2] <= res[2];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.blue_out  = r_out[0];
    assign o_res.green_out = r_out[1];
    assign o_res.red_out   = r_out[2];

endmodule

// ===== rtl/gli_front.sv =====
// ----------------------------------------------------------------------------
// gli_front
// Clamp one channel sample and scale it onto the node grid; present the
// node index and fraction to the curve store.
// ----------------------------------------------------------------------------
module gli_front
    import gli_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  t_depth_cfg                 i_cfg,
    input  logic [$clog2(MAX_NODES)-1:0] i_nm1,
    input  logic signed [SAMPLE_W-1:0] i_raw,
    output logic [$clog2(MAX_NODES)-1:0] o_idx,
    output logic [DEPTH_W-1:0]         o_frac
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int TW = DEPTH_W + IW;

    logic [DEPTH_W-1:0] n_v;
    logic [DEPTH_W-1:0] r_v;
    logic [TW-1:0]      r_t;
    logic [TW-1:0]      t_shift;

    // Clamp sample to 0..in_max
    always_comb begin
        if (i_raw[SAMPLE_W-1]) begin
            n_v = '0;
        end else if (i_raw[SAMPLE_W-2:DEPTH_W] != '0) begin
            n_v = i_cfg.in_max;
        end else if (i_raw[DEPTH_W-1:0] > i_cfg.in_max) begin
            n_v = i_cfg.in_max;
        end else begin
            n_v = i_raw[DEPTH_W-1:0];
        end
    end

    // Stage 1: clamped sample; stage 2: scaled position
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_t <= TW'(r_v) * TW'(i_nm1);
        end
    end

    // Split position into node index and fraction
    assign t_shift = r_t >> i_cfg.ib;
    assign o_idx   = t_shift[IW-1:0];
    assign o_frac  = r_t[DEPTH_W-1:0] & i_cfg.in_max;

endmodule

// ===== rtl/gli_node_mem.sv =====
// ----------------------------------------------------------------------------
// gli_node_mem
// Curve store of one channel, split into even and odd node banks so that a
// node and its successor are read in the same cycle.
// ----------------------------------------------------------------------------
module gli_node_mem
    import gli_pkg::*;
#(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int NODE_FRAC_BITS = NODE_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_we,
    input  logic [$clog2(MAX_NODES)-1:0] i_waddr,
    input  logic [NODE_FRAC_BITS:0]      i_wdata,
    input  logic [$clog2(MAX_NODES)-1:0] i_idx,
    output logic [NODE_FRAC_BITS:0]      o_c0,
    output logic [NODE_FRAC_BITS:0]      o_c1
);
    localparam int IW  = $clog2(MAX_NODES);
    localparam int W   = NODE_FRAC_BITS + 1;
    localparam int BD  = (MAX_NODES + 1) / 2;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

    logic [W-1:0]   r_even_mem [BD];
    logic [W-1:0]   r_odd_mem  [BD];
    logic [W-1:0]   r_even_rd;
    logic [W-1:0]   r_odd_rd;
    logic           r_par;
    logic [IW:0]    idx_p1;
    logic [BAW-1:0] even_ra;
    logic [BAW-1:0] odd_ra;
    logic [BAW-1:0] wa;

    assign idx_p1  = {1'b0, i_idx} + (IW+1)'(1);
    assign even_ra = BAW'(idx_p1[IW:1]);
    assign odd_ra  = BAW'(i_idx >> 1);
    assign wa      = BAW'(i_waddr >> 1);

    // Write a node into its bank
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            if (i_waddr[0]) begin
                r_odd_mem[wa] <= i_wdata;
            end else begin
                r_even_mem[wa] <= i_wdata;
            end
        end
    end

    // Read both neighbors, hold on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_even_rd <= r_even_mem[even_ra];
            r_odd_rd  <= r_odd_mem[odd_ra];
            r_par     <= i_idx[0];
        end
    end

    assign o_c0 = r_par ? r_odd_rd  : r_even_rd;
    assign o_c1 = r_par ? r_even_rd : r_odd_rd;

endmodule

// ===== rtl/gli_back.sv =====
// ----------------------------------------------------------------------------
// gli_back
// Interpolate between two curve nodes, scale to the output depth and
// saturate.
// ----------------------------------------------------------------------------
module gli_back
    import gli_pkg::*;
#(
    parameter int NODE_FRAC_BITS = NODE_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_depth_cfg              i_cfg,
    input  logic [DEPTH_W-1:0]      i_frac,
    input  logic [NODE_FRAC_BITS:0] i_c0,
    input  logic [NODE_FRAC_BITS:0] i_c1,
    output logic [DEPTH_W-1:0]      o_res
);
    localparam int W  = NODE_FRAC_BITS + 1;
    localparam int SW = W + DEPTH_W + 2;   // signed interpolation sum
    localparam int NW = W + DEPTH_W;       // non-negative numerator
    localparam int PW = NW + DEPTH_W;      // scaled product

    logic [DEPTH_W-1:0]  r_f;
    logic signed [W:0]   diff;
    logic signed [SW-1:0] r_p;
    logic [W-1:0]        r_c0;
    logic [SW-1:0]       c0_sh;
    logic signed [SW-1:0] sum;
    logic [NW-1:0]       r_num;
    logic [PW-1:0]       r_prod;
    logic [PW-1:0]       res;

    assign diff  = $signed({1'b0, i_c1}) - $signed({1'b0, i_c0});
    assign c0_sh = SW'(r_c0) << i_cfg.ib;
    assign sum   = $signed(c0_sh) + r_p;

    // Fraction aligned with node read; difference product; numerator; scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f    <= i_frac;
            r_p    <= SW'($signed({1'b0, r_f})) * SW'(diff);
            r_c0   <= i_c0;
            r_num  <= sum[SW-1] ? '0 : sum[NW-1:0];
            r_prod <= PW'(r_num) * PW'(i_cfg.out_max);
        end
    end

    // Drop fraction bits and saturate to output depth
    assign res   = r_prod >> (NODE_FRAC_BITS + int'(i_cfg.ib));
    assign o_res = (res > PW'(i_cfg.out_max)) ? i_cfg.out_max : res[DEPTH_W-1:0];

endmodule

// ===== tb/sv/rgb_gamma_lut_interp_chk.sv =====
// ----------------------------------------------------------------------------
// rgb_gamma_lut_interp_chk
// Watches the item, result and register channels of the gamma curve block.
// Keeps its own copy of the curve nodes and depth registers, works out the
// corrected pixel for every accepted pixel item and compares it, field by
// field, with the results in arrival order. Hands the number of pixels still
// owed and the failure count to the testbench top.
// ----------------------------------------------------------------------------
module rgb_gamma_lut_interp_chk
    import gli_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gli_in_if    i_pix,
    gli_out_if   i_res,
    gli_cfg_if   i_cfg,
    output int   o_pending,
    output int   o_fail_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct {
        int unsigned        seq;
        logic [DEPTH_W-1:0] blue;
        logic [DEPTH_W-1:0] green;
        logic [DEPTH_W-1:0] red;
    } t_corrected_pix;

    logic [BITS_W-1:0]             in_bits;
    logic [BITS_W-1:0]             out_depth;
    logic [CFG_DATA_W-1:0]         node_count;
    logic [NODE_FRAC_BITS_DEF:0]   curve [MAX_NODES_DEF];
    t_corrected_pix                corrected_q [$];
    int unsigned                   pix_seq;
    int                            fail_count;

    // Interpolate one channel on the curve and scale it to the output depth
    function automatic logic [DEPTH_W-1:0] gamma_correct_channel(
        input logic signed [SAMPLE_W-1:0] sample);
        longint ib, ob, n, in_max, out_max, v, t, idx, f, c0, c1, num, res;
        ib = (in_bits == 0) ? 1 : (in_bits > DEPTH_W) ? DEPTH_W : longint'(in_bits);
        ob = (out_depth == 0) ? 1 : (out_depth > DEPTH_W) ? DEPTH_W : longint'(out_depth);
        n  = (node_count < 2) ? 2 :
             (node_count > MAX_NODES_DEF) ? MAX_NODES_DEF : longint'(node_count);
        in_max  = (longint'(1) << ib) - 1;
        out_max = (longint'(1) << ob) - 1;

        // Clamp the sample to the input range
        if (sample < 0) begin
            v = 0;
        end else if (longint'(sample) > in_max) begin
            v = in_max;
        end else begin
            v = longint'(sample);
        end

        // Locate the segment and blend its two nodes
        t   = v * (n - 1);
        idx = t >> ib;
        f   = t & in_max;
        c0  = longint'(curve[idx]);
        c1  = longint'(curve[idx + 1]);
        num = (c0 << ib) + f * (c1 - c0);
        if (num < 0) begin
            num = 0;
        end

        // Scale, truncate and saturate
        res = (num * out_max) >> (NODE_FRAC_BITS_DEF + ib);
        if (res > out_max) begin
            res = out_max;
        end
        return res[DEPTH_W-1:0];
    endfunction

    always @(posedge i_clk) begin : track
        t_corrected_pix want;
        if (!i_rst_n) begin
            in_bits    = BITS_W'(IN_BITS_RST);
            out_depth  = BITS_W'(OUT_BITS_RST);
            node_count = CFG_DATA_W'(NODE_COUNT_RST);
            for (int k = 0; k < MAX_NODES_DEF; k++) begin
                curve[k] = '0;
            end
            corrected_q.delete();
            pix_seq    = 0;
            fail_count = 0;
        end else begin
            // Apply register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_INPUT_BITS:  in_bits    = i_cfg.data[BITS_W-1:0];
                    CFG_OUTPUT_BITS: out_depth  = i_cfg.data[BITS_W-1:0];
                    CFG_NODE_COUNT:  node_count = i_cfg.data;
                    default: ;
                endcase
            end

            // Compare each result with the oldest pixel still owed
            if (i_res.valid && i_res.ready) begin
                if (corrected_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("result b=%0d g=%0d r=%0d arrived with no pixel pending",
                                 i_res.blue_out, i_res.green_out, i_res.red_out);
                    end
                    fail_count++;
                end else begin
                    want = corrected_q.pop_front();
                    if ({i_res.blue_out, i_res.green_out, i_res.red_out} !==
                        {want.blue, want.green, want.red}) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("pixel %0d: expected b=%0d g=%0d r=%0d,",
                                     want.seq, want.blue, want.green, want.red);
                            $display("    got b=%0d g=%0d r=%0d",
                                     i_res.blue_out, i_res.green_out, i_res.red_out);
                        end
                        fail_count++;
                    end
                end
            end

            // Store node writes, predict pixels
            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.kind == KIND_NODE) begin
                    curve[i_pix.node_index] = i_pix.node_value;
                end else begin
                    want.seq   = pix_seq;
                    want.blue  = gamma_correct_channel(i_pix.blue_in);
                    want.green = gamma_correct_channel(i_pix.green_in);
                    want.red   = gamma_correct_channel(i_pix.red_in);
                    corrected_q.push_back(want);
                    pix_seq++;
                end
            end
        end
        o_pending    <= corrected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/rgb_gamma_lut_interp_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_gamma_lut_interp_tb
// Drives the gamma curve block with curve loads and pixels under a range of
// depth and node count settings, from the narrowest to the widest and past
// the register limits. Both the item sender and the result receiver idle at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module rgb_gamma_lut_interp_tb;
    import gli_pkg::*;

    localparam int PIPE_LAT     = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 100;
    localparam int RAND_PHASES  = 11;
    localparam int UNITY        = 1 << NODE_FRAC_BITS_DEF;
    localparam int NODE_MAX_VAL = (1 << (NODE_FRAC_BITS_DEF + 1)) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it

    typedef enum int {
        CURVE_RISE,
        CURVE_FALL,
        CURVE_STEEP,
        CURVE_NOISE
    } t_curve_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   burst_left    = 0;
    int   idle_cycles   = 0;
    int   nodes_sent    = 0;
    int   pixels_sent   = 0;
    int   settings_used = 0;
    int   cur_in_max;
    int   cur_nodes;

    gli_in_if  pix_if ();
    gli_out_if res_if ();
    gli_cfg_if cfg_if ();

    rgb_gamma_lut_interp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    rgb_gamma_lut_interp_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when no item moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("** rgb_gamma_lut_interp: FAILED **");
            $finish;
        end
    end

    // Stall the result side: short runs and stalls, a few long ones
    initial begin : result_stalls
        int r, run, stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r     = $urandom_range(0, 99);
            run   = (r < 10) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            stall = (r < 10) ? 0 : (r < 92) ? $urandom_range(0, 3) : $urandom_range(15, 60);
            res_if.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Mostly short gaps, some long ones, and gap-free bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Channel sample: in range, at and past the edges, negative or anything
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SAMPLE_W'(cur_in_max);
            2:       return SAMPLE_W'(cur_in_max + 1);
            3:       return -int'($urandom_range(1, 1000));
            4:       return $urandom;
            default: return SAMPLE_W'($urandom_range(0, cur_in_max));
        endcase
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input logic kind, input logic [NIDX_W-1:0] index,
                             input logic [NODE_FRAC_BITS_DEF:0] value,
                             input logic signed [SAMPLE_W-1:0] blue,
                             input logic signed [SAMPLE_W-1:0] green,
                             input logic signed [SAMPLE_W-1:0] red);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.kind       <= kind;
        pix_if.node_index <= index;
        pix_if.node_value <= value;
        pix_if.blue_in    <= blue;
        pix_if.green_in   <= green;
        pix_if.red_in     <= red;
        do @(posedge i_clk); while (!pix_if.ready);
        if (kind == KIND_PIXEL) begin
            pixels_sent++;
        end else begin
            nodes_sent++;
        end
    endtask

    // Node write with junk in the sample fields
    task automatic send_node(input logic [NIDX_W-1:0] index,
                             input logic [NODE_FRAC_BITS_DEF:0] value);
        send_item(KIND_NODE, index, value, $urandom, $urandom, $urandom);
    endtask

    // Pixel with junk in the node fields
    task automatic send_pixel(input logic signed [SAMPLE_W-1:0] blue,
                              input logic signed [SAMPLE_W-1:0] green,
                              input logic signed [SAMPLE_W-1:0] red);
        send_item(KIND_PIXEL, NIDX_W'($urandom), 17'($urandom), blue, green, red);
    endtask

    // Drop valid and hold until every owed pixel has come back
    task automatic drain_results();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Present one register write; valid stays high for the next one
    task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Wait for the pipe to empty, then write all three registers
    task automatic write_curve_config(input logic [BITS_W-1:0] ib,
                                      input logic [BITS_W-1:0] ob,
                                      input logic [CFG_DATA_W-1:0] nc);
        drain_results();
        repeat (PIPE_LAT + 3) @(posedge i_clk);
        if ($urandom_range(0, 3) == 0) begin
            put_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
        put_reg(CFG_INPUT_BITS, {4'($urandom), ib});
        put_reg(CFG_OUTPUT_BITS, {4'($urandom), ob});
        put_reg(CFG_NODE_COUNT, nc);
        cfg_if.valid <= 1'b0;
        cur_in_max = (1 << ((ib == 0) ? 1 : (ib > DEPTH_W) ? DEPTH_W : int'(ib))) - 1;
        cur_nodes  = (nc < 2) ? 2 : (nc > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(nc);
        settings_used++;
    endtask

    // Load every node in use with a fresh curve
    task automatic load_curve();
        t_curve_shape shape;
        int level;
        shape = t_curve_shape'($urandom_range(0, 3));
        for (int k = 0; k < cur_nodes; k++) begin
            case (shape)
                CURVE_RISE:  level = k * UNITY / (cur_nodes - 1);
                CURVE_FALL:  level = (cur_nodes - 1 - k) * UNITY / (cur_nodes - 1);
                CURVE_STEEP: level = k * NODE_MAX_VAL / (cur_nodes - 1);
                default:     level = $urandom_range(0, NODE_MAX_VAL);
            endcase
            level = level + int'($urandom_range(0, 400)) - 200;
            level = (level < 0) ? 0 : (level > NODE_MAX_VAL) ? NODE_MAX_VAL : level;
            send_node(NIDX_W'(k), 17'(level));
        end
    endtask

    // One setting: load a curve, then pixels with live node rewrites
    task automatic run_curve_phase(input logic [BITS_W-1:0] ib,
                                   input logic [BITS_W-1:0] ob,
                                   input logic [CFG_DATA_W-1:0] nc);
        write_curve_config(ib, ob, nc);
        load_curve();
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                drain_results();
            end
            if ($urandom_range(0, 99) < 12) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_node(NIDX_W'($urandom), 17'($urandom));
                end else begin
                    send_node(NIDX_W'($urandom_range(0, cur_nodes - 1)),
                              17'($urandom_range(0, NODE_MAX_VAL)));
                end
            end else begin
                send_pixel(pick_sample(), pick_sample(), pick_sample());
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        pix_if.valid      <= 1'b0;
        pix_if.kind       <= KIND_NODE;
        pix_if.node_index <= '0;
        pix_if.node_value <= '0;
        pix_if.blue_in    <= '0;
        pix_if.green_in   <= '0;
        pix_if.red_in     <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_INPUT_BITS;
        cfg_if.data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Widest depths on a two-node curve
        write_curve_config(5'd16, 5'd16, 9'd2);
        send_node(8'd0, 17'd0);
        send_node(8'd1, 17'(UNITY));
        send_node(8'd255, 17'(NODE_MAX_VAL));
        send_pixel(0, 65535, 32768);
        send_pixel(-1, 32'sh8000_0000, 32'sh7fff_ffff);
        send_pixel(65536, 1, 65534);
        // Node above unity read right after its write
        send_node(8'd1, 17'(NODE_MAX_VAL));
        send_pixel(65535, 49152, 16384);
        // Falling segment
        send_node(8'd0, 17'(UNITY));
        send_node(8'd1, 17'd0);
        send_pixel(0, 65535, 21845);

        // Register values below range saturate to the narrowest setting
        write_curve_config(5'd0, 5'd0, 9'd0);
        send_pixel(0, 1, 2);
        send_pixel(-7, 1, 0);
        send_node(8'd1, 17'd98304);
        send_pixel(1, 1, 0);

        // Random part over extreme and random settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: run_curve_phase(5'd1, 5'd1, 9'd2);
                1: run_curve_phase(5'd16, 5'd16, 9'd256);
                2: run_curve_phase(5'd31, 5'd31, 9'd511);
                3: run_curve_phase(BITS_W'(IN_BITS_RST), BITS_W'(OUT_BITS_RST),
                                   CFG_DATA_W'(NODE_COUNT_RST));
                4: run_curve_phase(5'd0, 5'd16, 9'd1);
                5: run_curve_phase(5'd16, 5'd1, 9'd17);
                6: run_curve_phase(5'd8, 5'd12, 9'd65);
                default: run_curve_phase(BITS_W'($urandom_range(1, 16)),
                                         BITS_W'($urandom_range(1, 16)),
                                         CFG_DATA_W'($urandom_range(2, 48)));
            endcase
        end

        drain_results();
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        $display("Sent %0d node writes and %0d pixels under %0d curve settings,",
                 nodes_sent, pixels_sent, settings_used);
        $display("depths 1..16 and node counts 2..256, register values past both ends.");
        if (fail_count == 0 && pending == 0) begin
            $display("** rgb_gamma_lut_interp: PASSED **");
        end else begin
            $display("%0d failures, %0d pixels never returned", fail_count, pending);
            $display("** rgb_gamma_lut_interp: FAILED **");
        end
        $finish;
    end

endmodule
